// ===== rtl/three_rotor_substitution_cipher_macros.svh =====
// Assertion helpers for the rotor cipher.
// Both macros sample on clk_i; the first one is masked while rst_ni is low.
`ifndef THREE_ROTOR_SUBSTITUTION_CIPHER_MACROS_SVH
`define THREE_ROTOR_SUBSTITUTION_CIPHER_MACROS_SVH

// Checked only out of reset.
`define TRSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define TRSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/trsc_pkg.sv =====
package trsc_pkg;

  localparam int AlphaSize = 26;
  localparam int NumRotors = 3;

  localparam logic [7:0] UPPER_BASE = 8'd65;
  localparam logic [7:0] UPPER_LAST = 8'd90;
  localparam logic [7:0] LOWER_BASE = 8'd97;
  localparam logic [7:0] LOWER_LAST = 8'd122;
  localparam logic [4:0] MAX_ENTRY  = 5'd25;
  localparam logic [4:0] STEP_WRAP  = 5'(AlphaSize);

  typedef logic [4:0] sym_t;   // letter index / rotor offset, 0..25
  typedef logic [4:0] cnt_t;   // step counter, 0..26
  typedef logic [1:0] rsel_t;  // rotor select

  typedef enum logic {
    MODE_CHAR = 1'b0,
    MODE_LOAD = 1'b1
  } mode_e;

  // (a + b) mod 26 for a, b in 0..25
  function automatic sym_t add_mod(sym_t a, sym_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'(AlphaSize)) begin
      s = s - 6'(AlphaSize);
    end
    return s[4:0];
  endfunction

  function automatic sym_t advance(sym_t a);
    return add_mod(a, 5'd1);
  endfunction

endpackage

// ===== rtl/trsc_in_if.sv =====
interface trsc_in_if;
  import trsc_pkg::*;

  logic  valid;
  logic  ready;
  mode_e mode;
  logic  [7:0] char_in;
  rsel_t rotor_sel;
  logic  [4:0] position;
  logic  [4:0] entry;

  modport source (output valid, mode, char_in, rotor_sel, position, entry, input ready);
  modport sink   (input valid, mode, char_in, rotor_sel, position, entry, output ready);
endinterface

// ===== rtl/trsc_out_if.sv =====
interface trsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       load_error;

  modport source (output valid, char_out, load_error, input ready);
  modport sink   (input valid, char_out, load_error, output ready);
endinterface

// ===== rtl/three_rotor_substitution_cipher.sv =====
// Three-rotor substitution cipher on a byte stream. Each input beat is either a
// character (mode 0) or a load of one rotor table entry (mode 1); every beat gives
// exactly one result beat. Letters of either case go through rotor 1, 2 and 3 and
// keep their case; any other byte passes unchanged. Rotor 1 steps after every
// letter; every 26 letters rotor 2 steps, every 26 steps of rotor 2 rotor 3 steps,
// both applied as the next character beat comes in. A load with entry above 25 is
// dropped and flagged on load_error; any other load clears all rotor offsets and
// step counters and, if rotor_sel and position are in range, writes the entry.
// Load results carry char_out = 0. Throughput is one beat per clock while results
// are taken; a beat passes an input register, then the rotor chain
// (three mod-26 adds and three 26-entry table reads) into the result register.
// The result register lets a new beat enter while a result waits to be taken.
// Rotor tables reset to all zeros, offsets and counters to zero.
`include "three_rotor_substitution_cipher_macros.svh"

module three_rotor_substitution_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  trsc_in_if.sink     in_i,
  trsc_out_if.source  out_o
);
  import trsc_pkg::*;

  // input stage
  logic        s1_valid_q;
  mode_e       s1_mode_q;
  logic [7:0]  s1_char_q;
  rsel_t       s1_sel_q;
  logic [4:0]  s1_pos_q;
  logic [4:0]  s1_entry_q;

  // result stage
  logic        out_valid_q;
  logic [7:0]  out_char_q, out_char_d;
  logic        out_err_q, out_err_d;

  // cipher state
  sym_t rotor_q [NumRotors][AlphaSize];
  sym_t off1_q, off1_d, off2_q, off2_d, off3_q, off3_d;
  cnt_t cnt1_q, cnt1_d, cnt2_q, cnt2_d;

  logic adv;         // input stage moves into result stage
  logic in_fire;
  logic is_letter;
  logic [7:0] base;
  sym_t idx, k1, k2, k3, v1, v2, v3;
  sym_t off2_c, off3_c;
  cnt_t cnt1_c, cnt2_c;
  logic load_ok, tbl_we;

  assign adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_fire = in_i.valid && in_i.ready;

  assign in_i.ready      = !s1_valid_q || adv;
  assign out_o.valid     = out_valid_q;
  assign out_o.char_out  = out_char_q;
  assign out_o.load_error = out_err_q;

  // ---------------------------------------------------------------------------
  // Rotor datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    // pending cascade steps
    cnt1_c = cnt1_q;
    cnt2_c = cnt2_q;
    off2_c = off2_q;
    off3_c = off3_q;
    if (cnt1_q >= STEP_WRAP) begin
      cnt1_c = '0;
      cnt2_c = cnt2_q + 5'd1;
      off2_c = advance(off2_q);
    end
    if (cnt2_c >= STEP_WRAP) begin
      cnt2_c = '0;
      off3_c = advance(off3_q);
    end

    // letter classification
    is_letter = 1'b0;
    base      = UPPER_BASE;
    if (s1_char_q >= UPPER_BASE && s1_char_q <= UPPER_LAST) begin
      is_letter = 1'b1;
    end else if (s1_char_q >= LOWER_BASE && s1_char_q <= LOWER_LAST) begin
      is_letter = 1'b1;
      base      = LOWER_BASE;
    end
    idx = 5'(s1_char_q - base);

    // three chained lookups; stored entries are always 0..25
    k1 = add_mod(idx, off1_q);
    v1 = rotor_q[0][k1];
    k2 = add_mod(v1, off2_c);
    v2 = rotor_q[1][k2];
    k3 = add_mod(v2, off3_c);
    v3 = rotor_q[2][k3];

    load_ok = (s1_entry_q <= MAX_ENTRY);
    tbl_we  = 1'b0;

    off1_d     = off1_q;
    off2_d     = off2_q;
    off3_d     = off3_q;
    cnt1_d     = cnt1_q;
    cnt2_d     = cnt2_q;
    out_char_d = '0;
    out_err_d  = 1'b0;

    case (s1_mode_q)
      MODE_LOAD: begin
        if (load_ok) begin
          tbl_we = (s1_sel_q < 2'(NumRotors)) && (s1_pos_q < 5'(AlphaSize));
          off1_d = '0;
          off2_d = '0;
          off3_d = '0;
          cnt1_d = '0;
          cnt2_d = '0;
        end else begin
          out_err_d = 1'b1;
        end
      end
      MODE_CHAR: begin
        off2_d = off2_c;
        off3_d = off3_c;
        cnt2_d = cnt2_c;
        cnt1_d = cnt1_c;
        if (is_letter) begin
          out_char_d = base + {3'b000, v3};
          off1_d     = advance(off1_q);
          cnt1_d     = cnt1_c + 5'd1;
        end else begin
          out_char_d = s1_char_q;
        end
      end
      default: begin
        out_char_d = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      off1_q      <= '0;
      off2_q      <= '0;
      off3_q      <= '0;
      cnt1_q      <= '0;
      cnt2_q      <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        off1_q      <= off1_d;
        off2_q      <= off2_d;
        off3_q      <= off3_d;
        cnt1_q      <= cnt1_d;
        cnt2_q      <= cnt2_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // rotor tables: reset value is all zeros
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRotors; r++) begin
        for (int p = 0; p < AlphaSize; p++) begin
          rotor_q[r][p] <= '0;
        end
      end
    end else if (adv && tbl_we) begin
      rotor_q[s1_sel_q][s1_pos_q] <= s1_entry_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q  <= in_i.mode;
      s1_char_q  <= in_i.char_in;
      s1_sel_q   <= in_i.rotor_sel;
      s1_pos_q   <= in_i.position;
      s1_entry_q <= in_i.entry;
    end
    if (adv) begin
      out_char_q <= out_char_d;
      out_err_q  <= out_err_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TRSC_ASSERT_ALWAYS(a_offsets_in_range, (off1_q < 5'(AlphaSize)) && (off2_q < 5'(AlphaSize)) && (off3_q < 5'(AlphaSize)), "rotor offset out of range")
  `TRSC_ASSERT(a_cascade_wraps, (adv && s1_mode_q == MODE_CHAR && cnt1_q == STEP_WRAP) |=> (cnt1_q <= 5'd1), "first counter did not wrap")
  `TRSC_ASSERT(a_reject_keeps_state, (adv && s1_mode_q == MODE_LOAD && !load_ok) |=> ($stable(off1_q) && $stable(cnt1_q) && $stable(cnt2_q) && out_err_q), "rejected load changed state")
  `TRSC_ASSERT(a_pass_through, (adv && s1_mode_q == MODE_CHAR && !is_letter) |=> (out_char_q == $past(s1_char_q) && !out_err_q), "non-letter byte altered")

endmodule

// ===== verif/three_rotor_substitution_cipher_tb.sv =====
// Testbench for the three-rotor substitution cipher.
// One sender task drives input beats and predicts each result at acceptance;
// one checker process pops the oldest prediction per output beat. A receiver
// process toggles out ready at random and can hold it low for a long stretch.
module three_rotor_substitution_cipher_tb;
  import trsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          MAX_PRINTS  = 40;   // keep the log short on a bad run

  typedef struct packed {
    logic [7:0] char_out;
    logic       load_error;
  } cipher_res_t;

  logic clk_i;
  logic rst_ni;

  trsc_in_if  in_if ();
  trsc_out_if out_if ();

  three_rotor_substitution_cipher i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow state of the cipher
  logic [4:0] rotor_mem [NumRotors][AlphaSize];
  sym_t       rotor_off [NumRotors];
  cnt_t       step_cnt  [2];          // [0]: rotor 1 steps, [1]: rotor 2 steps

  cipher_res_t expected_cipher_q[$];
  cipher_res_t oldest_expected;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_off_cycles;       // receiver stall request, counted down
  int          mismatch_cnt;
  int unsigned sent_cnt;
  int unsigned cycle_cnt;

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial cycle_cnt = 0;
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still expected",
             cycle_cnt, expected_cipher_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Computes the result of one beat and updates the shadow state.
  function automatic cipher_res_t cipher_predict(mode_e m, logic [7:0] ch, rsel_t sel,
                                                 logic [4:0] pos, logic [4:0] ent);
    cipher_res_t r;
    int          idx;
    int          base;
    r = '0;
    if (m == MODE_LOAD) begin
      // Out-of-range entry: rejected, nothing changes at all
      if (ent > MAX_ENTRY) begin
        r.load_error = 1'b1;
      end else begin
        // sel 3 or pos > 25 writes nothing but still clears the rotation
        if (sel < NumRotors && pos < AlphaSize) begin
          rotor_mem[sel][pos] = ent;
        end
        for (int k = 0; k < NumRotors; k++) rotor_off[k] = '0;
        step_cnt[0] = '0;
        step_cnt[1] = '0;
      end
      return r;
    end

    // Pending cascade steps run for every character beat, letter or not
    if (step_cnt[0] >= STEP_WRAP) begin
      step_cnt[0]  = '0;
      step_cnt[1]  = step_cnt[1] + 5'd1;
      rotor_off[1] = 5'((rotor_off[1] + 1) % AlphaSize);
    end
    if (step_cnt[1] >= STEP_WRAP) begin
      step_cnt[1]  = '0;
      rotor_off[2] = 5'((rotor_off[2] + 1) % AlphaSize);
    end

    base = -1;
    if (ch >= UPPER_BASE && ch <= UPPER_LAST) begin
      base = UPPER_BASE;
    end else if (ch >= LOWER_BASE && ch <= LOWER_LAST) begin
      base = LOWER_BASE;
    end

    if (base < 0) begin
      r.char_out = ch;
    end else begin
      idx = ch - base;
      // entry k of a rotor turned by r sits at stored index (k + r) mod 26
      for (int k = 0; k < NumRotors; k++) begin
        idx = rotor_mem[k][(idx + rotor_off[k]) % AlphaSize] % AlphaSize;
      end
      r.char_out   = 8'(base + idx);
      rotor_off[0] = 5'((rotor_off[0] + 1) % AlphaSize);
      step_cnt[0]  = step_cnt[0] + 5'd1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    if (mismatch_cnt < MAX_PRINTS) begin
      $display("[%0t] MISMATCH %s", $time, what);
    end
    mismatch_cnt++;
  endtask

  // One input beat; random idle cycles ahead of it, prediction at acceptance.
  // valid is assigned at most once per falling edge, so back-to-back beats keep
  // it high without a glitch.
  task automatic send_beat(input mode_e m, input logic [7:0] ch, input rsel_t sel,
                           input logic [4:0] pos, input logic [4:0] ent);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= m;
    in_if.char_in   <= ch;
    in_if.rotor_sel <= sel;
    in_if.position  <= pos;
    in_if.entry     <= ent;
    do @(posedge clk_i); while (!in_if.ready);
    expected_cipher_q.push_back(cipher_predict(m, ch, sel, pos, ent));
    sent_cnt++;
  endtask

  // Load fields are don't-care on a character beat and vice versa: randomize them
  task automatic send_char(input logic [7:0] ch);
    send_beat(MODE_CHAR, ch, rsel_t'($urandom_range(0, 3)), 5'($urandom),
              5'($urandom));
  endtask

  task automatic load_entry(input rsel_t sel, input logic [4:0] pos, input logic [4:0] ent);
    send_beat(MODE_LOAD, 8'($urandom), sel, pos, ent);
  endtask

  // Mostly letters of either case, now and then any byte
  function automatic logic [7:0] pick_char(int letter_pct);
    logic [7:0] ofs;
    ofs = 8'($urandom_range(0, AlphaSize - 1));
    if ($urandom_range(0, 99) < letter_pct) begin
      return ($urandom_range(0, 1) != 0 ? UPPER_BASE : LOWER_BASE) + ofs;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Writes a random permutation into one rotor
  task automatic load_permutation(input rsel_t sel);
    int perm [AlphaSize];
    int j;
    int tmp;
    for (int i = 0; i < AlphaSize; i++) perm[i] = i;
    for (int i = AlphaSize - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < AlphaSize; i++) load_entry(sel, 5'(i), 5'(perm[i]));
  endtask

  // Sender goes quiet first, so the last beat is not offered again
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_cipher_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random ready, or held low while a stall is requested
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Checker: each output beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_cipher_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result char_out=%0d load_error=%0b",
                                  out_if.char_out, out_if.load_error));
      end else begin
        oldest_expected = expected_cipher_q.pop_front();
        if (out_if.char_out !== oldest_expected.char_out) begin
          report_mismatch($sformatf("char_out got %0d want %0d",
                                    out_if.char_out, oldest_expected.char_out));
        end
        if (out_if.load_error !== oldest_expected.load_error) begin
          report_mismatch($sformatf("load_error got %b want %b",
                                    out_if.load_error, oldest_expected.load_error));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Field extremes, letter boundaries, every kind of load
  task automatic test_directed();
    send_char(UPPER_BASE);                 // all-zero tables map every letter to 'A' or 'a' by its case
    load_entry(2'd0, 5'd0, MAX_ENTRY);     // largest accepted entry
    load_entry(2'd2, 5'd25, 5'd0);
    load_entry(2'd1, 5'd12, 5'd7);
    send_char(UPPER_BASE);
    load_entry(2'd0, 5'd3, 5'd26);         // rejected: smallest bad entry
    load_entry(2'd3, 5'd31, 5'd31);        // rejected, all bits set
    send_char(LOWER_BASE);
    load_entry(2'd3, 5'd5, 5'd3);          // no such rotor: only clears rotation
    load_entry(2'd0, 5'd26, 5'd4);         // position past the table
    load_entry(2'd1, 5'd31, 5'd0);
    send_char(UPPER_LAST);
    send_char(LOWER_LAST);
    send_char(UPPER_BASE - 8'd1);          // bytes just outside the letter ranges
    send_char(UPPER_LAST + 8'd1);
    send_char(LOWER_BASE - 8'd1);
    send_char(LOWER_LAST + 8'd1);
    send_char(8'd0);
    send_char(8'hFF);
    send_char(8'd48);
    send_char(LOWER_BASE + 8'd4);
  endtask

  // Well-formed setup: a permutation in every rotor
  task automatic test_table_fill();
    for (int s = 0; s < NumRotors; s++) load_permutation(rsel_t'(s));
  endtask

  // Long run without loads: crosses rotor 2 steps and at least one rotor 3 step
  // (needs more than 26 * 26 letters)
  task automatic test_long_stream(input int n_chars);
    for (int i = 0; i < n_chars; i++) send_char(pick_char(93));
  endtask

  // Sessions of loads (with noise) followed by character bursts of random length
  task automatic test_random_mix(input int n_beats);
    int unsigned stop_at;
    int          n_loads;
    int          roll;
    stop_at = sent_cnt + n_beats;
    while (sent_cnt < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        load_permutation(rsel_t'($urandom_range(0, NumRotors - 1)));
      end else begin
        n_loads = $urandom_range(1, 10);
        for (int i = 0; i < n_loads; i++) begin
          roll = $urandom_range(0, 99);
          if (roll < 10) begin
            load_entry(rsel_t'($urandom_range(0, 3)), 5'($urandom),
                       5'($urandom_range(26, 31)));
          end else if (roll < 15) begin
            load_entry(2'd3, 5'($urandom), 5'($urandom_range(0, 25)));
          end else if (roll < 20) begin
            load_entry(rsel_t'($urandom_range(0, 2)), 5'($urandom_range(26, 31)),
                       5'($urandom_range(0, 25)));
          end else begin
            load_entry(rsel_t'($urandom_range(0, 2)), 5'($urandom_range(0, 25)),
                       5'($urandom_range(0, 25)));
          end
        end
      end
      n_loads = $urandom_range(10, 120);
      for (int i = 0; i < n_loads && sent_cnt < stop_at; i++) send_char(pick_char(85));
    end
  endtask

  // Receiver stalls for a long stretch while beats keep coming, so the block
  // fills and drops in ready; then the sender waits for every result
  task automatic test_backpressure();
    drain_results();
    hold_off_cycles = 120;
    for (int i = 0; i < 30; i++) send_char(pick_char(90));
    drain_results();
    for (int i = 0; i < 8; i++) send_char(pick_char(90));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int s = 0; s < NumRotors; s++) begin
      for (int p = 0; p < AlphaSize; p++) rotor_mem[s][p] = '0;
      rotor_off[s] = '0;
    end
    step_cnt[0]     = '0;
    step_cnt[1]     = '0;
    mismatch_cnt    = 0;
    sent_cnt        = 0;
    hold_off_cycles = 0;
    send_idle_pct   = 17;
    recv_idle_pct   = 52;

    in_if.valid     = 1'b0;
    in_if.mode      = MODE_CHAR;
    in_if.char_in   = '0;
    in_if.rotor_sel = '0;
    in_if.position  = '0;
    in_if.entry     = '0;

    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sender idles 17 %, receiver 52 %
    test_directed();
    test_table_fill();
    test_long_stream(850);

    // the other way round
    send_idle_pct = 52;
    recv_idle_pct = 17;
    test_random_mix(500);

    // no random idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_mix(250);

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    drain_results();
    // wait on to catch any extra result beat
    repeat (10) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_cipher_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
